// ===== sv/bilinear_gain_schedule_lookup_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gain schedule lookup
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GAIN_SCHEDULE_LOOKUP_DEFINES_SVH
`define BILINEAR_GAIN_SCHEDULE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define BGSL_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define BGSL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/bgsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bgsl_pkg
// Shared constants, codes and control structs of the gain schedule lookup.
// ----------------------------------------------------------------------------
package bgsl_pkg;

   localparam int MACH_PTS   = 16;
   localparam int ALT_PTS    = 16;
   localparam int NUM_GAINS  = 21;
   localparam int IDX_W      = 4;
   localparam int GSEL_W     = 5;
   localparam int CNT_W      = 5;
   localparam int VAL_W      = 32;
   localparam int FRAC_W     = 17;
   localparam int DIV_STEPS  = 17;
   localparam int TAB_ADDR_W = GSEL_W + 2 * IDX_W;
   localparam int TAB_DEPTH  = NUM_GAINS * ALT_PTS * MACH_PTS;
   localparam int CSR_IDX_W  = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MACH_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALT_COUNT  = 1'b1;

   typedef enum logic [1:0] {
      OP_WR_MACH = 2'd0,
      OP_WR_ALT  = 2'd1,
      OP_WR_GAIN = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_ROW0 = 2'd1,
      MUL_ROW1 = 2'd2,
      MUL_ALT  = 2'd3
   } mul_op_type;

   typedef struct packed {
      logic              wr_en;
      logic              q_ld;
      logic              axis;      // 0 Mach, 1 altitude
      logic              bp_rd;
      logic [IDX_W-1:0]  bp_addr;
      logic              cap_lo;
      logic              div_ld;
      logic              div_step;
      logic              frac_st;
      logic              tab_rd;
      logic [IDX_W-1:0]  tab_row;
      logic [IDX_W-1:0]  tab_col;
      logic [GSEL_W-1:0] gain;
      logic              cap_en;
      logic [1:0]        cap_idx;
      mul_op_type        mul_op;
      logic              t1_ld;
      logic              t2_ld;
      logic              out_ld;
   } cmd_type;

   typedef struct packed {
      logic bp_gt;
      logic out_free;
   } status_type;

   // breakpoint count in use, clamped to 2..max
   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] max);
      logic [CNT_W-1:0] r;
      r = c;
      if (c < CNT_W'(2)) r = CNT_W'(2);
      else if (c > max) r = max;
      return r;
   endfunction

endpackage

// ===== sv/bgsl_if.sv =====
// ----------------------------------------------------------------------------
// bgsl channel interfaces
// Query/load channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface bgsl_req_if import bgsl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [GSEL_W-1:0]       gain_select;
   logic [IDX_W-1:0]        row;
   logic [IDX_W-1:0]        col;
   logic signed [VAL_W-1:0] write_value;
   logic signed [VAL_W-1:0] mach_number;
   logic signed [VAL_W-1:0] altitude;
   modport source (output valid, op, gain_select, row, col, write_value, mach_number,
                   altitude, input ready);
   modport sink (input valid, op, gain_select, row, col, write_value, mach_number,
                 altitude, output ready);
endinterface

interface bgsl_rsp_if import bgsl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [GSEL_W-1:0]       gain_index;
   logic signed [VAL_W-1:0] gain_value;
   logic                    last;
   modport source (output valid, gain_index, gain_value, last, input ready);
   modport sink (input valid, gain_index, gain_value, last, output ready);
endinterface

interface bgsl_csr_if import bgsl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CNT_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/bgsl_datapath.sv =====
// ----------------------------------------------------------------------------
// bgsl_datapath
// Breakpoint and gain memories, fraction divider, shared lerp multiplier
// and the result word register.
// ----------------------------------------------------------------------------
module bgsl_datapath import bgsl_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [1:0]              req_op,
   input  logic [GSEL_W-1:0]       req_gain_select,
   input  logic [IDX_W-1:0]        req_row,
   input  logic [IDX_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_write_value,
   input  logic signed [VAL_W-1:0] req_mach_number,
   input  logic signed [VAL_W-1:0] req_altitude,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [GSEL_W-1:0]       rsp_gain_index,
   output logic signed [VAL_W-1:0] rsp_gain_value,
   output logic                    rsp_last
);

   logic signed [VAL_W-1:0] mach_mem [MACH_PTS];
   logic signed [VAL_W-1:0] alt_mem [ALT_PTS];
   logic signed [VAL_W-1:0] gain_mem [TAB_DEPTH];

   logic signed [VAL_W-1:0] mach_q_ff, alt_q_ff, tab_q_ff;
   logic signed [VAL_W-1:0] mq_ff, aq_ff, lo_ff;
   logic [VAL_W+1:0]        rem_ff;
   logic [VAL_W:0]          dvs_ff;
   logic [FRAC_W-1:0]       quo_ff, fm_ff, fa_ff;
   logic                    dz_ff;
   logic signed [VAL_W-1:0] e_ff [4];
   logic signed [VAL_W-1:0] t1_ff, t2_ff;
   logic signed [50:0]      prod_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [GSEL_W-1:0]       idx_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    last_ff;

   logic signed [VAL_W-1:0] bp_q, v, vc;
   logic signed [VAL_W:0]   dx, dw;
   logic [VAL_W:0]          mx, mw;
   logic                    ge;
   logic [VAL_W+1:0]        rsub;
   logic signed [VAL_W:0]   da;
   logic signed [FRAC_W:0]  fs;
   logic signed [VAL_W-1:0] base;
   logic signed [35:0]      lsum;
   logic signed [VAL_W-1:0] sat;
   logic [TAB_ADDR_W-1:0]   wr_addr, rd_addr;

   // breakpoint stores
   always_ff @(posedge clock) begin
      if (cmd.wr_en && req_op == OP_WR_MACH) mach_mem[req_col] <= req_write_value;
      if (cmd.bp_rd) mach_q_ff <= mach_mem[cmd.bp_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && req_op == OP_WR_ALT) alt_mem[req_row] <= req_write_value;
      if (cmd.bp_rd) alt_q_ff <= alt_mem[cmd.bp_addr];
   end

   // gain store, address {gain, row, col}
   assign wr_addr = {req_gain_select, req_row, req_col};
   assign rd_addr = {cmd.gain, cmd.tab_row, cmd.tab_col};

   always_ff @(posedge clock) begin
      if (cmd.wr_en && req_op == OP_WR_GAIN && req_gain_select < GSEL_W'(NUM_GAINS))
         gain_mem[wr_addr] <= req_write_value;
      if (cmd.tab_rd) tab_q_ff <= gain_mem[rd_addr];
   end

   // search compare and clamp
   assign bp_q = cmd.axis ? alt_q_ff : mach_q_ff;
   assign v    = cmd.axis ? aq_ff : mq_ff;
   assign status.bp_gt = bp_q > v;

   always_comb begin
      vc = v;
      if (v < lo_ff) vc = lo_ff;
      else if (v > bp_q) vc = bp_q;
      dx = {vc[VAL_W-1], vc} - {lo_ff[VAL_W-1], lo_ff};
      dw = {bp_q[VAL_W-1], bp_q} - {lo_ff[VAL_W-1], lo_ff};
      mx = dx[VAL_W] ? VAL_W'(0) - dx : dx;
      mw = dw[VAL_W] ? VAL_W'(0) - dw : dw;
   end

   // restoring divide step
   assign ge   = rem_ff >= {1'b0, dvs_ff};
   assign rsub = ge ? rem_ff - {1'b0, dvs_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.q_ld) begin
         mq_ff <= req_mach_number;
         aq_ff <= req_altitude;
      end
      if (cmd.cap_lo) lo_ff <= bp_q;
      if (cmd.div_ld) begin
         rem_ff <= {1'b0, mx};
         dvs_ff <= mw;
         dz_ff  <= (mw == '0);
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rsub[VAL_W:0], 1'b0};
         quo_ff <= {quo_ff[FRAC_W-2:0], ge};
      end
      if (cmd.frac_st) begin
         if (cmd.axis) fa_ff <= dz_ff ? '0 : quo_ff;
         else          fm_ff <= dz_ff ? '0 : quo_ff;
      end
   end

   // shared lerp multiplier
   always_comb begin
      da = '0;
      fs = '0;
      case (cmd.mul_op)
         MUL_ROW0: begin
            da = {e_ff[1][VAL_W-1], e_ff[1]} - {e_ff[0][VAL_W-1], e_ff[0]};
            fs = {1'b0, fm_ff};
         end
         MUL_ROW1: begin
            da = {e_ff[3][VAL_W-1], e_ff[3]} - {e_ff[2][VAL_W-1], e_ff[2]};
            fs = {1'b0, fm_ff};
         end
         MUL_ALT: begin
            da = {t2_ff[VAL_W-1], t2_ff} - {t1_ff[VAL_W-1], t1_ff};
            fs = {1'b0, fa_ff};
         end
         default: begin
            da = '0;
            fs = '0;
         end
      endcase
   end

   // lerp add: base + floor(prod / 65536)
   always_comb begin
      base = t1_ff;
      if (cmd.t1_ld) base = e_ff[0];
      else if (cmd.t2_ld) base = e_ff[2];
      lsum = {{4{base[VAL_W-1]}}, base} + {prod_ff[50], prod_ff[50:16]};
      sat = lsum[VAL_W-1:0];
      if (lsum > 36'sh07FFFFFFF) sat = {1'b0, {(VAL_W-1){1'b1}}};
      else if (lsum < -36'sh080000000) sat = {1'b1, {(VAL_W-1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_en) e_ff[cmd.cap_idx] <= tab_q_ff;
      if (cmd.mul_op != MUL_NONE) prod_ff <= da * fs;
      if (cmd.t1_ld) t1_ff <= lsum[VAL_W-1:0];
      if (cmd.t2_ld) t2_ff <= lsum[VAL_W-1:0];
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_ld) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      if (cmd.out_ld) begin
         idx_ff  <= cmd.gain;
         val_ff  <= sat;
         last_ff <= (cmd.gain == GSEL_W'(NUM_GAINS - 1));
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gain_index = idx_ff;
   assign rsp_gain_value = val_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== sv/bgsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgsl_ctrl
// Sequencer: count registers, bracket search, divider passes and the
// per-gain read/multiply schedule.
// ----------------------------------------------------------------------------
module bgsl_ctrl import bgsl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_ready,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data,
   output logic                 csr_ready,
   output cmd_type              cmd,
   input  status_type           status
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_RD_LO, S_RD_HI, S_PREP, S_DIV, S_FRAC, S_GAIN
   } state_type;

   localparam logic [CNT_W-1:0] STEP_MUL0 = CNT_W'(3);
   localparam logic [CNT_W-1:0] STEP_T1   = CNT_W'(4);
   localparam logic [CNT_W-1:0] STEP_MUL1 = CNT_W'(5);
   localparam logic [CNT_W-1:0] STEP_T2   = CNT_W'(6);
   localparam logic [CNT_W-1:0] STEP_MULA = CNT_W'(7);
   localparam logic [CNT_W-1:0] STEP_OUT  = CNT_W'(8);

   state_type         state_ff;
   logic [CNT_W-1:0]  mach_cnt_ff, alt_cnt_ff;
   logic              axis_ff;
   logic [IDX_W-1:0]  i_ff, kb_ff, ka_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [GSEL_W-1:0] g_ff;

   logic [CNT_W-1:0]  n;
   logic [IDX_W-1:0]  k_new, k_cur;
   logic              scan_end;

   assign n = axis_ff ? eff_count(alt_cnt_ff, CNT_W'(ALT_PTS))
                      : eff_count(mach_cnt_ff, CNT_W'(MACH_PTS));
   assign scan_end = status.bp_gt || ({1'b0, i_ff} == n - CNT_W'(2));
   assign k_new = status.bp_gt ? ((i_ff == '0) ? IDX_W'(1) : i_ff)
                               : IDX_W'(n - CNT_W'(1));
   assign k_cur = axis_ff ? ka_ff : kb_ff;

   // state and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mach_cnt_ff <= CNT_W'(MACH_PTS);
         alt_cnt_ff  <= CNT_W'(ALT_PTS);
         axis_ff     <= 1'b0;
         i_ff        <= '0;
         kb_ff       <= '0;
         ka_ff       <= '0;
         cnt_ff      <= '0;
         g_ff        <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MACH_COUNT: mach_cnt_ff <= csr_data;
               CSR_ALT_COUNT:  alt_cnt_ff  <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_op == OP_QUERY) begin
                  state_ff <= S_SCAN_RD;
                  axis_ff  <= 1'b0;
                  i_ff     <= '0;
               end
            end
            S_SCAN_RD: state_ff <= S_SCAN_CMP;
            S_SCAN_CMP: begin
               if (scan_end) begin
                  if (axis_ff) ka_ff <= k_new;
                  else         kb_ff <= k_new;
                  state_ff <= S_RD_LO;
               end else begin
                  i_ff     <= i_ff + IDX_W'(1);
                  state_ff <= S_SCAN_RD;
               end
            end
            S_RD_LO: state_ff <= S_RD_HI;
            S_RD_HI: state_ff <= S_PREP;
            S_PREP: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_ff <= S_FRAC;
               else cnt_ff <= cnt_ff + CNT_W'(1);
            end
            S_FRAC: begin
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  i_ff     <= '0;
                  state_ff <= S_SCAN_RD;
               end else begin
                  g_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_GAIN;
               end
            end
            S_GAIN: begin
               if (cnt_ff == STEP_OUT) begin
                  if (status.out_free) begin
                     cnt_ff <= '0;
                     if (g_ff == GSEL_W'(NUM_GAINS - 1)) state_ff <= S_IDLE;
                     else g_ff <= g_ff + GSEL_W'(1);
                  end
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // command decode
   always_comb begin
      cmd         = '0;
      cmd.mul_op  = MUL_NONE;
      cmd.axis    = axis_ff;
      cmd.gain    = g_ff;
      cmd.tab_row = cnt_ff[1] ? ka_ff : ka_ff - IDX_W'(1);
      cmd.tab_col = cnt_ff[0] ? kb_ff : kb_ff - IDX_W'(1);
      cmd.cap_idx = 2'(cnt_ff - CNT_W'(1));
      cmd.bp_addr = i_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.wr_en = req_valid;
            cmd.q_ld  = req_valid && req_op == OP_QUERY;
         end
         S_SCAN_RD: cmd.bp_rd = 1'b1;
         S_RD_LO: begin
            cmd.bp_rd   = 1'b1;
            cmd.bp_addr = k_cur - IDX_W'(1);
         end
         S_RD_HI: begin
            cmd.bp_rd   = 1'b1;
            cmd.bp_addr = k_cur;
            cmd.cap_lo  = 1'b1;
         end
         S_PREP: cmd.div_ld = 1'b1;
         S_DIV:  cmd.div_step = 1'b1;
         S_FRAC: cmd.frac_st = 1'b1;
         S_GAIN: begin
            cmd.tab_rd = cnt_ff < CNT_W'(4);
            cmd.cap_en = cnt_ff >= CNT_W'(1) && cnt_ff <= CNT_W'(4);
            cmd.t1_ld  = cnt_ff == STEP_T1;
            cmd.t2_ld  = cnt_ff == STEP_T2;
            cmd.out_ld = cnt_ff == STEP_OUT && status.out_free;
            if (cnt_ff == STEP_MUL0)      cmd.mul_op = MUL_ROW0;
            else if (cnt_ff == STEP_MUL1) cmd.mul_op = MUL_ROW1;
            else if (cnt_ff == STEP_MULA) cmd.mul_op = MUL_ALT;
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/bilinear_gain_schedule_lookup.sv =====
// ----------------------------------------------------------------------------
// bilinear_gain_schedule_lookup
// Mach/altitude gain scheduling: bracket search, clamp and bilinear
// interpolation of 21 gain tables in signed Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req_ch   in   op, gain_select, row, col, write_value, mach_number, altitude
//  rsp_ch   out  gain_index, gain_value, last (21 words per query)
//  csr_ch   in   index, data (breakpoint counts)
//
//  Load words are taken while idle. A query runs accept, then per axis a search
//  (up to n-1 breakpoints compared), lo/hi reads, divider setup, a 17-step
//  restoring divider and one store, then per gain the table reads, the row and
//  altitude lerps on the shared multiplier and the result word.
//  Reset returns both counts to 16; stores are not cleared.
//  A stalled result word holds the next gain at its last step.
// ----------------------------------------------------------------------------
`include "bilinear_gain_schedule_lookup_defines.svh"

module bilinear_gain_schedule_lookup import bgsl_pkg::*; (
   input logic        clock,
   input logic        reset,
   bgsl_req_if.sink   req_ch,
   bgsl_rsp_if.source rsp_ch,
   bgsl_csr_if.sink   csr_ch
);

   cmd_type    cmd;
   status_type status;

   bgsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .csr_ready (csr_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bgsl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_ch.op),
      .req_gain_select (req_ch.gain_select),
      .req_row         (req_ch.row),
      .req_col         (req_ch.col),
      .req_write_value (req_ch.write_value),
      .req_mach_number (req_ch.mach_number),
      .req_altitude    (req_ch.altitude),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_gain_index  (rsp_ch.gain_index),
      .rsp_gain_value  (rsp_ch.gain_value),
      .rsp_last        (rsp_ch.last)
   );

   // last word always carries the final gain index
   `BGSL_ASSERT_IMPL(a_last_idx, clock, reset, rsp_ch.valid && rsp_ch.last,
                     rsp_ch.gain_index == GSEL_W'(NUM_GAINS - 1))
   // a query leaves the block busy
   `BGSL_ASSERT_NEXT(a_query_busy, clock, reset,
                     req_ch.valid && req_ch.ready && req_ch.op == OP_QUERY,
                     !req_ch.ready)
   // result words come only from a gain index in range
   `BGSL_ASSERT_IMPL(a_idx_range, clock, reset, rsp_ch.valid,
                     rsp_ch.gain_index < GSEL_W'(NUM_GAINS))

endmodule
